// ===== rtl/aco_pkg.sv =====
// ----------------------------------------------------------------------------
// aco_pkg
// Shared types and constants of the Aho-Corasick matcher: word layouts of the
// automaton memory, the input and result words, and the decoded operation.
// ----------------------------------------------------------------------------
package aco_pkg;

  // automaton memory size, a power of two
  localparam int MEM_WORDS   = 4096;
  localparam int ADDR_BITS   = $clog2(MEM_WORDS);
  localparam int SYMBOL_BITS = 8;
  localparam int COUNT_BITS  = 16;

  // fixed field widths of the words on the ports
  localparam int IN_ADDR_BITS = 12;
  localparam int IN_SYM_BITS  = 8;
  localparam int DATA_BITS    = 32;
  localparam int POS_BITS     = 16;

  // node header: suffix offset, end mark, edge count
  localparam int OFF_BITS       = 16;
  localparam int HDR_END_BIT    = 16;
  localparam int HDR_CNT_LSB    = 17;
  localparam int EDGE_CNT_BITS  = DATA_BITS - HDR_CNT_LSB;
  // edge word: symbol in the low half, child offset in the high half
  localparam int EDGE_CHILD_LSB = 16;

  // walk counters hold MEM_WORDS itself
  localparam int LOOP_BITS = ADDR_BITS + 1;
  localparam int CMP_BITS  = (EDGE_CNT_BITS > LOOP_BITS) ? EDGE_CNT_BITS : LOOP_BITS;
  localparam int SUM_BITS  = ADDR_BITS + OFF_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // word queues between the parts
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } aco_kind_t;

  typedef struct packed {
    logic                    command;
    logic [IN_ADDR_BITS-1:0] word_address;
    logic [DATA_BITS-1:0]    word_data;
    logic [IN_SYM_BITS-1:0]  symbol;
    logic                    first_of_string;
  } aco_in_t;

  typedef struct packed {
    logic                match_found;
    logic [POS_BITS-1:0] match_position;
  } aco_out_t;

  typedef struct packed {
    aco_kind_t              kind;
    logic [ADDR_BITS-1:0]   addr;
    logic [DATA_BITS-1:0]   data;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   restart;
  } aco_op_t;

endpackage

// ===== rtl/aco_front.sv =====
// ----------------------------------------------------------------------------
// aco_front
// Input side: takes words, decodes them into write or scan operations and
// holds them in a short queue for the walk engine.
// ----------------------------------------------------------------------------
module aco_front import aco_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  aco_in_t in_word,
  output logic    op_valid,
  output aco_op_t op,
  input  logic    op_pop
);

  aco_op_t                q_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]     fill_r, fill_nxt;
  logic                   do_push, do_pop;
  aco_op_t                dec_op;

  assign full     = (fill_r == (QPTR_BITS+1)'(QDEPTH));
  assign op_valid = (fill_r != '0);
  assign op       = q_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = op_pop && op_valid;

  always_comb begin
    dec_op.kind    = in_word.command ? OP_SCAN : OP_WRITE;
    dec_op.addr    = ADDR_BITS'(in_word.word_address);
    dec_op.data    = in_word.word_data;
    dec_op.symbol  = SYMBOL_BITS'(in_word.symbol);
    dec_op.restart = in_word.first_of_string;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec_op;
    end
  end

endmodule

// ===== rtl/aco_engine.sv =====
// ----------------------------------------------------------------------------
// aco_engine
// Walk engine: owns the automaton memory, executes writes and walks the
// automaton for each scanned symbol of a string not yet matched, one memory read per cycle.
// ----------------------------------------------------------------------------
module aco_engine import aco_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     op_valid,
  input  aco_op_t  op,
  output logic     op_pop,
  input  logic     res_full,
  output logic     res_push,
  output aco_out_t res_word
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_EDGE,
    S_FIN
  } state_t;

  logic [DATA_BITS-1:0]   mem [MEM_WORDS];
  logic [DATA_BITS-1:0]   rdata_r;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic                   mem_we;

  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   node_r, node_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic                   matched_r, matched_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [OFF_BITS-1:0]    off_r, off_nxt;
  logic [CMP_BITS-1:0]    cap_r, cap_nxt;
  logic [CMP_BITS-1:0]    idx_r, idx_nxt;
  logic [LOOP_BITS-1:0]   steps_r, steps_nxt;

  logic [OFF_BITS-1:0]    sfx_off;
  logic                   sfx_stop;
  logic [ADDR_BITS-1:0]   sfx_node;
  logic [ADDR_BITS-1:0]   child_node;
  logic [CMP_BITS-1:0]    hdr_cap;
  logic [EDGE_CNT_BITS-1:0] hdr_cnt;
  logic                   edge_hit;

  function automatic logic [ADDR_BITS-1:0] add_signed(
    input logic [ADDR_BITS-1:0] base,
    input logic [OFF_BITS-1:0]  off
  );
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(base) + {{(SUM_BITS-OFF_BITS){off[OFF_BITS-1]}}, off};
    return s[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] add_unsigned(
    input logic [ADDR_BITS-1:0] base,
    input logic [OFF_BITS-1:0]  off
  );
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(base) + SUM_BITS'(off);
    return s[ADDR_BITS-1:0];
  endfunction

  // suffix link taken when no edge matches
  always_comb begin
    sfx_off  = (state_r == S_HDR) ? rdata_r[OFF_BITS-1:0] : off_r;
    sfx_stop = (sfx_off == '0) || (steps_r >= LOOP_BITS'(MEM_WORDS));
    sfx_node = add_signed(node_r, sfx_off);
  end

  always_comb begin
    hdr_cnt    = rdata_r[DATA_BITS-1:HDR_CNT_LSB];
    hdr_cap    = (CMP_BITS'(hdr_cnt) > CMP_BITS'(MEM_WORDS)) ?
                 CMP_BITS'(MEM_WORDS) : CMP_BITS'(hdr_cnt);
    edge_hit   = (rdata_r[SYMBOL_BITS-1:0] == sym_r);
    child_node = add_unsigned(node_r, rdata_r[DATA_BITS-1:EDGE_CHILD_LSB]);
  end

  always_comb begin
    state_nxt   = state_r;
    node_nxt    = node_r;
    count_nxt   = count_r;
    matched_nxt = matched_r;
    sym_nxt     = sym_r;
    off_nxt     = off_r;
    cap_nxt     = cap_r;
    idx_nxt     = idx_r;
    steps_nxt   = steps_r;
    rd_addr     = node_r;
    mem_we      = 1'b0;
    op_pop      = 1'b0;
    res_push    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (op_valid && !res_full) begin
          op_pop = 1'b1;
          if (op.kind == OP_WRITE) begin
            mem_we   = 1'b1;
            res_push = 1'b1;
          end else begin
            if (op.restart) begin
              node_nxt    = '0;
              count_nxt   = '0;
              matched_nxt = 1'b0;
            end
            // after a match the string is frozen until restart
            if (matched_nxt) begin
              res_push = 1'b1;
            end else begin
              sym_nxt   = op.symbol;
              steps_nxt = '0;
              rd_addr   = node_nxt;
              state_nxt = S_HDR;
            end
          end
        end
      end
      S_HDR: begin
        off_nxt = rdata_r[OFF_BITS-1:0];
        cap_nxt = hdr_cap;
        idx_nxt = '0;
        if (hdr_cap != '0) begin
          rd_addr   = node_r + ADDR_BITS'(1);
          state_nxt = S_EDGE;
        end else if (sfx_stop) begin
          rd_addr   = node_r;
          state_nxt = S_FIN;
        end else begin
          node_nxt  = sfx_node;
          steps_nxt = steps_r + LOOP_BITS'(1);
          rd_addr   = sfx_node;
        end
      end
      S_EDGE: begin
        if (edge_hit) begin
          node_nxt  = child_node;
          rd_addr   = child_node;
          state_nxt = S_FIN;
        end else if ((idx_r + CMP_BITS'(1)) < cap_r) begin
          idx_nxt = idx_r + CMP_BITS'(1);
          rd_addr = node_r + ADDR_BITS'(1) + idx_nxt[ADDR_BITS-1:0];
        end else if (sfx_stop) begin
          rd_addr   = node_r;
          state_nxt = S_FIN;
        end else begin
          node_nxt  = sfx_node;
          steps_nxt = steps_r + LOOP_BITS'(1);
          rd_addr   = sfx_node;
          state_nxt = S_HDR;
        end
      end
      S_FIN: begin
        // rdata_r holds the header of the node reached
        count_nxt   = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_BITS'(1);
        matched_nxt = matched_r | rdata_r[HDR_END_BIT];
        res_push    = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_word.match_found    = matched_nxt;
    res_word.match_position = POS_BITS'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      node_r    <= '0;
      count_r   <= '0;
      matched_r <= 1'b0;
      cap_r     <= '0;
      idx_r     <= '0;
      steps_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      node_r    <= node_nxt;
      count_r   <= count_nxt;
      matched_r <= matched_nxt;
      cap_r     <= cap_nxt;
      idx_r     <= idx_nxt;
      steps_r   <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    off_r <= off_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[op.addr] <= op.data;
    end
    rdata_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_walk_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDR || state_r == S_EDGE) |=> ($stable(count_r) && $stable(matched_r)))
    else $error("count or match changed during a walk");

  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE) |-> (idx_r < cap_r))
    else $error("edge index beyond edge count");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= LOOP_BITS'(MEM_WORDS))
    else $error("suffix step count beyond bound");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && count_r == COUNT_MAX) |=> (count_r == COUNT_MAX))
    else $error("symbol count wrapped");
`endif

endmodule

// ===== rtl/aco_out_queue.sv =====
// ----------------------------------------------------------------------------
// aco_out_queue
// Result side: a short queue of result words between the walk engine and
// the receiver, so the engine keeps going while a result waits.
// ----------------------------------------------------------------------------
module aco_out_queue import aco_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_push,
  input  aco_out_t res_word,
  output logic     res_full,
  output logic     empty,
  input  logic     pop,
  output aco_out_t out_word
);

  aco_out_t               q_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]     fill_r, fill_nxt;
  logic                   do_push, do_pop;

  assign res_full = (fill_r == (QPTR_BITS+1)'(QDEPTH));
  assign empty    = (fill_r == '0);
  assign out_word = q_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res_word;
    end
  end

endmodule

// ===== rtl/aho_corasick_matcher.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_matcher
// Streams symbols through an Aho-Corasick automaton held in a loadable
// word memory and reports the position of the first match in each string.
// ----------------------------------------------------------------------------
// Input channel: push / full with in_word. A word either writes one automaton
// memory word (command 0) or scans one symbol (command 1, first_of_string
// restarts at the root with count and match cleared).
// Result channel: empty / pop with out_word. Every input word gives exactly
// one result word: the match flag and the first match position, or the
// symbols counted so far when there is no match yet.
// The engine takes a word from the input queue and, for a write or a scan
// after a match, pushes its result word in that same cycle. A scan reads the
// node header, then the edge words one by one, follows suffix links when no
// edge matches and pushes its result from S_FIN, one memory read per cycle.
// The engine works on one word at a time, so the rate follows the automaton;
// a 4-deep queue on each side lets the sender and the receiver run ahead of
// it or stall on their own.
// Reset clears the queues, the node, the count and the match flag; the
// automaton memory keeps no reset value and must be loaded before a scan.
// When the receiver stalls the result queue fills, the engine waits and then
// the input queue fills and raises full.
// ----------------------------------------------------------------------------
module aho_corasick_matcher import aco_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  aco_in_t  in_word,
  output logic     empty,
  input  logic     pop,
  output aco_out_t out_word
);

  logic     op_valid;
  aco_op_t  op;
  logic     op_pop;
  logic     res_push;
  logic     res_full;
  aco_out_t res_word;

  aco_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  aco_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_word (res_word)
  );

  aco_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_word (res_word),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
